// ===== rtl/serial_command_frame_decoder_defines.svh =====
// Assertion macros shared by the serial command frame decoder RTL.
`ifndef SERIAL_COMMAND_FRAME_DECODER_DEFINES_SVH
`define SERIAL_COMMAND_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define SCFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define SCFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/scfd_pkg.sv =====
// Package with action codes, command kinds and shared types of the frame decoder.
package scfd_pkg;

	// Action codes carried by the first byte of a frame.
	localparam logic [4:0] ACT_MAX        = 5'd18;
	localparam logic [4:0] ACT_SLOT_COUNT = 5'd12;
	localparam logic [4:0] ACT_SPI        = 5'd12;
	localparam logic [4:0] ACT_DROPPED    = 5'd13;
	localparam logic [4:0] ACT_BROADCAST  = 5'd14;
	localparam logic [4:0] ACT_WRITE_IR   = 5'd15;
	localparam logic [4:0] ACT_INIT_PEAKS = 5'd16;
	localparam logic [4:0] ACT_CALC       = 5'd17;
	localparam logic [4:0] ACT_COMM       = 5'd18;

	// Decoded command kinds.
	localparam logic [2:0] KIND_WRITE_IR   = 3'd0;
	localparam logic [2:0] KIND_INIT_PEAKS = 3'd1;
	localparam logic [2:0] KIND_SPI        = 3'd2;
	localparam logic [2:0] KIND_CALC       = 3'd3;
	localparam logic [2:0] KIND_BROADCAST  = 3'd4;
	localparam logic [2:0] KIND_COMM       = 3'd5;
	localparam logic [2:0] KIND_STORE_SLOT = 3'd6;

	// Payload length limits and reset value.
	localparam logic [2:0] LEN_MIN   = 3'd1;
	localparam logic [2:0] LEN_MAX   = 3'd4;
	localparam logic [2:0] LEN_RESET = 3'd4;

	// One decoded command.
	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  slot;
		logic [31:0] value;
		logic [7:0]  arg;
		logic [7:0]  comm;
	} cmd_t;

	// Framer status seen by the top level.
	typedef struct packed {
		logic [2:0] seen;
		logic [4:0] action;
	} frm_status_t;

	// Clamp the configured length into the range 1 to 4.
	function automatic logic [2:0] eff_len(input logic [2:0] cfg);
		logic [2:0] n;
		n = cfg;
		if (n < LEN_MIN) n = LEN_MIN;
		if (n > LEN_MAX) n = LEN_MAX;
		return n;
	endfunction

endpackage

// ===== rtl/scfd_framer.sv =====
// Frame state of the decoder: action capture, payload packing and command decode.
module scfd_framer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	input  logic [2:0]          payload_bytes,
	output logic                res_valid,
	output scfd_pkg::cmd_t      res,
	output scfd_pkg::frm_status_t status
);
	import scfd_pkg::*;

	logic [2:0]  seen_q;
	logic [4:0]  action_q;
	logic [31:0] acc_q;
	logic [7:0]  comm_q;

	logic [2:0]  seen_d;
	logic [4:0]  action_d;
	logic [31:0] acc_d;
	logic [7:0]  comm_d;
	logic [2:0]  len;
	logic        done;

	assign len = eff_len(payload_bytes);

	// Next frame state for the byte in hand.
	always_comb begin
		seen_d   = seen_q;
		action_d = action_q;
		acc_d    = acc_q;
		done     = 1'b0;
		if (seen_q == 3'd0) begin
			if (rx_byte <= {3'd0, ACT_MAX}) begin
				action_d = rx_byte[4:0];
				acc_d    = '0;
				seen_d   = 3'd1;
			end
		end else begin
			acc_d = {acc_q[23:0], rx_byte};
			// seen_q equals the payload byte count including this byte.
			if (seen_q < len) begin
				seen_d = seen_q + 3'd1;
			end else begin
				seen_d = 3'd0;
				done   = 1'b1;
			end
		end
	end

	// Command decode of a finished frame.
	always_comb begin
		res_valid = 1'b0;
		comm_d    = comm_q;
		res.kind  = KIND_STORE_SLOT;
		res.slot  = 4'd0;
		res.value = acc_d;
		res.arg   = acc_d[31:24];
		if (done) begin
			res_valid = 1'b1;
			unique case (action_q)
				ACT_WRITE_IR:   res.kind = KIND_WRITE_IR;
				ACT_INIT_PEAKS: res.kind = KIND_INIT_PEAKS;
				ACT_SPI:        res.kind = KIND_SPI;
				ACT_CALC:       res.kind = KIND_CALC;
				ACT_BROADCAST:  res.kind = KIND_BROADCAST;
				ACT_COMM: begin
					res.kind = KIND_COMM;
					comm_d   = acc_d[31:24];
				end
				default: begin
					if (action_q < ACT_SLOT_COUNT) begin
						res.kind = KIND_STORE_SLOT;
						res.slot = action_q[3:0];
					end else begin
						// The dropped code and anything else gives no command.
						res_valid = 1'b0;
					end
				end
			endcase
		end
		res.comm = comm_d;
	end

	// Frame state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= 3'd0;
			action_q <= 5'd0;
			acc_q    <= '0;
			comm_q   <= 8'd0;
		end else if (step) begin
			seen_q   <= seen_d;
			action_q <= action_d;
			acc_q    <= acc_d;
			comm_q   <= comm_d;
		end
	end

	assign status.seen   = seen_q;
	assign status.action = action_q;

endmodule

// ===== rtl/serial_command_frame_decoder.sv =====
// Serial command frame decoder top level: input register, framer and result register.
//
// Usage: received serial bytes enter on rx_byte with in_valid; a byte is taken at a
// rising edge where in_valid is high and in_stall is low. The first byte of a frame is
// an action code; codes 0 to 18 are followed by payload_bytes payload bytes (1 to 4),
// packed most significant first. A finished frame yields one command on the output
// channel (out_valid, out_stall), except the dropped code and codes above 18.
// Path: the edge that takes the last byte of a frame loads the input register, and
// the framer's command is then loaded into the output register once advance is high,
// which raises out_valid; the command leaves at an edge where out_stall is low.
// Throughput: one byte per cycle when not stalled, set by the single framer state update.
// Stall: while a command waits under out_stall and a byte sits in the input register,
// that byte is held and in_stall is raised in the same cycle; nothing is lost or repeated.
// Configuration: cfg_data is written at an edge with cfg_valid and cfg_ready high; the
// user must write it only while the block is idle, which the block does not enforce.
// Reset: clears the frame state and the stored comm-enable byte and sets the payload
// length to four bytes; both channels come out of reset empty.
`include "serial_command_frame_decoder_defines.svh"

module serial_command_frame_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] command_kind,
	output logic [3:0] slot_index,
	output logic [31:0] payload_value,
	output logic [7:0] byte_argument,
	output logic [7:0] comm_enabled,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_data
);
	import scfd_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [2:0]  len_q;
	logic        out_valid_q;
	cmd_t        out_q;
	logic        advance;
	logic        res_valid;
	cmd_t        res;
	frm_status_t status;

	// The input stage moves on whenever the output register is free or draining.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign cfg_ready = !valid_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// Payload length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			len_q <= cfg_data;
		end
	end

	scfd_framer u_framer (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (valid_s1 && advance),
		.rx_byte       (byte_s1),
		.payload_bytes (len_q),
		.res_valid     (res_valid),
		.res           (res),
		.status        (status)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign command_kind  = out_q.kind;
	assign slot_index    = out_q.slot;
	assign payload_value = out_q.value;
	assign byte_argument = out_q.arg;
	assign comm_enabled  = out_q.comm;

	// Checks on the decoder's own logic.
	`SCFD_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall, out_valid_q && out_stall,
		"input stalled without a waiting command")
	`SCFD_ASSERT_NOW(a_seen_range, clk, arst_n, 1'b1, status.seen <= LEN_MAX,
		"frame byte count out of range")
	`SCFD_ASSERT_NOW(a_action_range, clk, arst_n, status.seen != 3'd0,
		status.action <= ACT_MAX, "pending action code out of range")
	`SCFD_ASSERT_NOW(a_comm_stored, clk, arst_n, out_valid_q && (out_q.kind == KIND_COMM),
		out_q.comm == out_q.arg, "comm enable byte not stored")
	`SCFD_ASSERT_NOW(a_slot_zero, clk, arst_n, out_valid_q && (out_q.kind != KIND_STORE_SLOT),
		out_q.slot == 4'd0, "slot set on a non-store command")

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the serial command frame decoder.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import scfd_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int ITEM_TARGET  = 1900;
	localparam int PHASE_COUNT  = 10;
	localparam int DRAIN_CYCLES = 4;
	localparam int LONG_HOLD    = 200;

	// Tracks the decoder's frame state and holds the commands it should still produce.
	class command_tracker;
		cmd_t        pending_cmds[$];
		logic [2:0]  length_cfg;
		logic [2:0]  bytes_seen;
		logic [4:0]  action;
		logic [31:0] shift_value;
		logic [7:0]  comm_byte;
		int          failures;

		function new();
			length_cfg  = LEN_RESET;
			bytes_seen  = '0;
			action      = '0;
			shift_value = '0;
			comm_byte   = '0;
			failures    = 0;
		endfunction

		function void set_length(logic [2:0] n);
			length_cfg = n;
		endfunction

		// Zero counts as one byte, anything above four counts as four.
		function int frame_length();
			if (length_cfg < LEN_MIN)
				return LEN_MIN;
			if (length_cfg > LEN_MAX)
				return LEN_MAX;
			return length_cfg;
		endfunction

		// Notes one accepted byte and queues the command it completes, if any.
		function void take_byte(logic [7:0] b);
			cmd_t c;
			if (bytes_seen == 0) begin
				if (b <= ACT_MAX) begin
					action      = b[4:0];
					shift_value = '0;
					bytes_seen  = 3'd1;
				end
				return;
			end
			shift_value = {shift_value[23:0], b};
			bytes_seen  = bytes_seen + 3'd1;
			if (int'(bytes_seen) - 1 < frame_length())
				return;
			bytes_seen = '0;
			c.value = shift_value;
			c.arg   = shift_value[31:24];
			c.slot  = '0;
			case (action)
				ACT_WRITE_IR:   c.kind = KIND_WRITE_IR;
				ACT_INIT_PEAKS: c.kind = KIND_INIT_PEAKS;
				ACT_SPI:        c.kind = KIND_SPI;
				ACT_CALC:       c.kind = KIND_CALC;
				ACT_BROADCAST:  c.kind = KIND_BROADCAST;
				ACT_COMM: begin
					c.kind    = KIND_COMM;
					comm_byte = c.arg;
				end
				ACT_DROPPED:    return;
				default: begin
					c.kind = KIND_STORE_SLOT;
					c.slot = action[3:0];
				end
			endcase
			c.comm = comm_byte;
			pending_cmds.push_back(c);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				failures++;
			end
		endfunction

		// Compares one command transaction with the oldest expected command.
		function void match_command(cmd_t got);
			cmd_t want;
			if (pending_cmds.size() == 0) begin
				$error("command_kind: expected no command, got 0x%0h", got.kind);
				failures++;
				return;
			end
			want = pending_cmds.pop_front();
			check_field("command_kind", want.kind, got.kind);
			check_field("slot_index", want.slot, got.slot);
			check_field("payload_value", want.value, got.value);
			check_field("byte_argument", want.arg, got.arg);
			check_field("comm_enabled", want.comm, got.comm);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  command_kind;
	logic [3:0]  slot_index;
	logic [31:0] payload_value;
	logic [7:0]  byte_argument;
	logic [7:0]  comm_enabled;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_data;

	command_tracker tracker = new();
	int  items_sent;
	int  hold_left;
	int  cycle_count;
	bit  calm_tx;
	bit  calm_rx;

	serial_command_frame_decoder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.command_kind (command_kind),
		.slot_index   (slot_index),
		.payload_value(payload_value),
		.byte_argument(byte_argument),
		.comm_enabled (comm_enabled),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Every handshake is observed here, on the values present before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.take_byte(rx_byte);
			if (out_valid && !out_stall)
				tracker.match_command({command_kind, slot_index, payload_value,
					byte_argument, comm_enabled});
			if (cfg_valid && cfg_ready)
				tracker.set_length(cfg_data);
		end
	end

	// Receiver: random stalls, plus a long hold-off counted down here when requested.
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = pick_gap(calm_rx);
			end
		end
	end

	// Watchdog on the total run length.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// Offers one byte after a random gap and returns once the transaction is taken.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap(calm_tx);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Sends an action byte and the low n bytes of data, most significant first.
	task automatic send_frame(input logic [7:0] act, input logic [31:0] data, input int n);
		send_byte(act);
		for (int i = n - 1; i >= 0; i--)
			send_byte(data[8*i +: 8]);
	endtask

	// Stops sending, waits for every expected command and lets the pipeline empty.
	task automatic wait_all_decoded();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending_cmds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(input logic [2:0] n);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= n;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One random frame with the current length, or now and then a lone ignored code.
	task automatic send_random_frame();
		int         n;
		logic [7:0] b;
		if ($urandom_range(99) < 8) begin
			send_byte($urandom_range(ACT_MAX + 1, 255));
			items_sent += 1;
			return;
		end
		n = tracker.frame_length();
		send_byte($urandom_range(0, ACT_MAX));
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0:       b = 8'h00;
				1:       b = 8'hFF;
				default: b = $urandom_range(0, 255);
			endcase
			send_byte(b);
		end
		items_sent += n + 1;
	endtask

	initial begin
		logic [2:0] phase_len [PHASE_COUNT];
		int         phase_target;
		phase_len = '{3'd4, 3'd1, 3'd7, 3'd0, 3'd2, 3'd5, 3'd3, 3'd6, 3'd4, 3'd1};
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		rx_byte    = '0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		hold_left  = 0;
		calm_tx    = 1'b0;
		calm_rx    = 1'b0;
		items_sent = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset length of four: full-scale store to slot zero, comm enable, ignored codes.
		send_frame(8'd0, 32'hFFFF_FFFF, 4);
		send_frame(ACT_COMM, 32'hA500_0001, 4);
		send_byte(ACT_MAX + 1);
		send_byte(8'hFF);

		// One-byte payloads: every other command, the dropped code, top byte reads zero.
		wait_all_decoded();
		write_length(3'd1);
		send_frame(ACT_SLOT_COUNT - 1, 32'h0, 1);
		send_frame(ACT_SPI, 32'h80, 1);
		send_frame(ACT_DROPPED, 32'h7F, 1);
		send_frame(ACT_BROADCAST, 32'h01, 1);
		send_frame(ACT_WRITE_IR, 32'hFE, 1);
		send_frame(ACT_INIT_PEAKS, 32'h55, 1);
		send_frame(ACT_CALC, 32'hAA, 1);

		// A length of zero acts as one byte; comm enable is cleared again.
		wait_all_decoded();
		write_length(3'd0);
		send_frame(ACT_COMM, 32'h00, 1);

		// Length above four acts as four; shortening it mid-frame ends the frame early.
		wait_all_decoded();
		write_length(3'd7);
		send_frame(ACT_WRITE_IR, 32'h1122, 2);
		wait_all_decoded();
		write_length(3'd2);
		send_byte(8'h33);

		// Random phases, each under its own length and idling mix.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			wait_all_decoded();
			write_length(p < 8 ? phase_len[p] : 3'($urandom_range(0, 7)));
			calm_tx = ($urandom_range(3) == 0);
			calm_rx = ($urandom_range(3) == 0);
			// One phase keeps the receiver stalled while bytes arrive back to back.
			if (p == 2) begin
				calm_tx   = 1'b1;
				hold_left = LONG_HOLD;
			end
			phase_target = (p + 1) * ITEM_TARGET / PHASE_COUNT;
			while (items_sent < phase_target)
				send_random_frame();
			// Sometimes leave a frame open so the next length applies mid-frame.
			if ($urandom_range(1) == 1) begin
				send_byte($urandom_range(0, ACT_MAX));
				repeat ($urandom_range(0, 3))
					send_byte($urandom_range(0, 255));
			end
		end

		calm_rx = 1'b0;
		wait_all_decoded();
		if (tracker.failures == 0 && tracker.pending_cmds.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
